@@ rtl/core/rsfb_pkg.sv @@
// Shared types and constants for the feedback bus slave timing block.
package rsfb_pkg;

  localparam int unsigned RegW   = 8;
  localparam int unsigned CfgIdxW = 3;

  // Event kinds carried on the input side-band
  typedef enum logic [1:0] {
    FN_EDGE = 2'd0,
    FN_TICK = 2'd1,
    FN_SEND = 2'd2,
    FN_CONN = 2'd3
  } func_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_OWN_ADDR  = 3'd0,
    REG_MAX_ADDR  = 3'd1,
    REG_IDLE_LIM  = 3'd2,
    REG_CYC_EDGES = 3'd3,
    REG_INACT_LIM = 3'd4
  } cfg_idx_t;

  // Register reset values
  localparam logic [RegW-1:0] OwnAddrRst  = 8'd0;
  localparam logic [RegW-1:0] MaxAddrRst  = 8'd128;
  localparam logic [RegW-1:0] IdleLimRst  = 8'd4;
  localparam logic [RegW-1:0] CycEdgesRst = 8'd130;
  localparam logic [RegW-1:0] InactLimRst = 8'd200;

  typedef struct packed {
    logic [RegW-1:0] own_address;
    logic [RegW-1:0] max_address;
    logic [RegW-1:0] idle_limit;
    logic [RegW-1:0] cycle_edges;
    logic [RegW-1:0] inactive_limit;
  } cfg_t;

  typedef struct packed {
    logic            tx_valid;
    logic [RegW-1:0] tx_byte;
    logic            bus_active;
    logic            link_connected;
    logic            send_pending;
  } res_t;

endpackage

@@ rtl/core/rsfb_cfg.sv @@
// Configuration register bank for the feedback bus slave timing block.
module rsfb_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rsfb_pkg::CfgIdxW-1:0]  cfg_addr,
  input  logic [rsfb_pkg::RegW-1:0]     cfg_wdata,
  output rsfb_pkg::cfg_t                cfg
);
  import rsfb_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register write decode; unknown indexes are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_OWN_ADDR:  cfg_nxt.own_address    = cfg_wdata;
        REG_MAX_ADDR:  cfg_nxt.max_address    = cfg_wdata;
        REG_IDLE_LIM:  cfg_nxt.idle_limit     = cfg_wdata;
        REG_CYC_EDGES: cfg_nxt.cycle_edges    = cfg_wdata;
        REG_INACT_LIM: cfg_nxt.inactive_limit = cfg_wdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address    <= OwnAddrRst;
      cfg_r.max_address    <= MaxAddrRst;
      cfg_r.idle_limit     <= IdleLimRst;
      cfg_r.cycle_edges    <= CycEdgesRst;
      cfg_r.inactive_limit <= InactLimRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/rsfb_core.sv @@
// Bus timing and send handshake: one event update per evt_fire cycle.
module rsfb_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      evt_fire,
  input  rsfb_pkg::func_t           evt_func,
  input  logic [rsfb_pkg::RegW-1:0] evt_data,
  input  rsfb_pkg::cfg_t            cfg,
  output rsfb_pkg::res_t            res
);
  import rsfb_pkg::*;

  logic [RegW-1:0] polled_r,   polled_nxt;
  logic [RegW-1:0] idle_r,     idle_nxt;
  logic [RegW-1:0] inact_r,    inact_nxt;
  logic            active_r,   active_nxt;
  logic            conn_r,     conn_nxt;
  logic            pend_r,     pend_nxt;
  logic [RegW-1:0] pbyte_r,    pbyte_nxt;
  logic [RegW-1:0] idle_inc;
  logic [RegW-1:0] inact_inc;
  logic            own_turn;

  assign own_turn  = (cfg.own_address == polled_r) && active_r;
  assign idle_inc  = idle_r + RegW'(1);
  assign inact_inc = inact_r + RegW'(1);

  // Next state and result for the event in hand
  always_comb begin
    polled_nxt   = polled_r;
    idle_nxt     = idle_r;
    inact_nxt    = inact_r;
    active_nxt   = active_r;
    conn_nxt     = conn_r;
    pend_nxt     = pend_r;
    pbyte_nxt    = pbyte_r;
    res.tx_valid = 1'b0;
    res.tx_byte  = '0;
    unique case (evt_func)
      FN_EDGE: begin
        if (pend_r) begin
          if (own_turn) begin
            // address zero never transmits but still consumes the byte
            if (cfg.own_address != '0) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = pbyte_r;
            end
            pend_nxt = 1'b0;
          end else if (cfg.own_address > cfg.max_address) begin
            pend_nxt = 1'b0;
          end
        end
        polled_nxt = polled_r + RegW'(1);
        idle_nxt   = '0;
      end
      FN_TICK: begin
        inact_nxt = inact_inc;
        idle_nxt  = idle_inc;
        // idle gap ends a polling cycle
        if (idle_inc > cfg.idle_limit) begin
          idle_nxt = '0;
          if (polled_r == cfg.cycle_edges) begin
            active_nxt = 1'b1;
            inact_nxt  = '0;
          end else begin
            active_nxt = 1'b0;
          end
          polled_nxt = '0;
        end
        // inactivity timeout
        if (inact_nxt >= cfg.inactive_limit) begin
          active_nxt = 1'b0;
          conn_nxt   = 1'b0;
          pend_nxt   = 1'b0;
          inact_nxt  = '0;
        end
      end
      FN_SEND: begin
        pbyte_nxt = evt_data;
        pend_nxt  = 1'b1;
      end
      FN_CONN: begin
        conn_nxt = 1'b1;
      end
      default: begin
        conn_nxt = conn_r;
      end
    endcase
    res.bus_active     = active_nxt;
    res.link_connected = conn_nxt;
    res.send_pending   = pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      polled_r <= '0;
      idle_r   <= '0;
      inact_r  <= '0;
      active_r <= 1'b0;
      conn_r   <= 1'b0;
      pend_r   <= 1'b0;
      pbyte_r  <= '0;
    end else if (evt_fire) begin
      polled_r <= polled_nxt;
      idle_r   <= idle_nxt;
      inact_r  <= inact_nxt;
      active_r <= active_nxt;
      conn_r   <= conn_nxt;
      pend_r   <= pend_nxt;
      pbyte_r  <= pbyte_nxt;
    end
  end

endmodule

@@ rtl/core/rs_bus_feedback_slave_timing.sv @@
// Top level of the feedback bus slave timing block.
//
// Input stream: one beat per event. in_tuser carries the event kind (bus edge,
// ms tick, send request, mark connected); in_tdata carries the byte to send.
// Output stream: exactly one beat per input beat, in order. out_tuser is the
// transmit strobe, out_tdata holds the byte to transmit (zero when no byte is
// handed out) and the active, connected and pending flags after the event.
// Configuration: cfg_we writes register cfg_addr with cfg_wdata, no read-back;
// write only while no beat is in flight.
// Pipeline: input register, then one combinational state update into the
// output register.
// Throughput: one beat per cycle unless stalled; the state registers update
// once per event as it passes from the input to the output register.
// Reset (rst_n low, synchronous): both stages empty, all timing state and
// flags cleared, registers at their defaults.
// Stall: while out_tready is low the output beat holds, one more beat waits in
// the input register, then in_tready drops until the output drains.
module rs_bus_feedback_slave_timing (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,  // [7:0] data_byte
  input  logic [1:0]                    in_tuser,  // [1:0] func
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] tx_byte, [8] bus_active, [9] link_connected, [10] send_pending, [15:11] zero
  output logic [15:0]                   out_tdata,
  output logic                          out_tuser, // [0] tx_valid
  input  logic                          cfg_we,
  input  logic [rsfb_pkg::CfgIdxW-1:0]  cfg_addr,
  input  logic [rsfb_pkg::RegW-1:0]     cfg_wdata
);
  import rsfb_pkg::*;

  cfg_t            cfg;
  res_t            res;
  logic            s1_valid_r;
  func_t           s1_func_r;
  logic [RegW-1:0] s1_data_r;
  logic            out_valid_r;
  res_t            out_res_r;
  logic            adv;
  logic            in_fire;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  rsfb_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  rsfb_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .evt_fire(adv),
    .evt_func(s1_func_r),
    .evt_data(s1_data_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= func_t'(in_tuser);
      s1_data_r <= in_tdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.tx_valid;
  assign out_tdata  = {5'b0, out_res_r.send_pending, out_res_r.link_connected,
                       out_res_r.bus_active, out_res_r.tx_byte};

endmodule

@@ rtl/core/rsfb_checker.sv @@
// Port-level checks for the feedback bus slave timing block, bound to the top.
module rsfb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // A transmitted byte leaves nothing pending
  a_tx_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> !out_tdata[10])
    else $error("tx beat still shows a pending byte");

  // Transmit only while the bus is active
  a_tx_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tdata[8])
    else $error("tx beat while bus inactive");

  // No strobe means a zero byte
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[7:0] == 8'd0))
    else $error("nonzero byte without tx strobe");

  // A stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("output beat changed under stall");

endmodule

bind rs_bus_feedback_slave_timing rsfb_checker u_rsfb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
